/* hdl/vti_pkg.sv */
// Shared constants, codes and tables for the voxel trilinear interpolator.
// No dependencies; every other file but vti_fifo refers to it by scoped names.
package vti_pkg;

    localparam int INDEX_W   = 15;
    localparam int COORD_W   = 21;
    localparam int DIM_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int SXY_W     = 2 * DIM_W;
    localparam int NUM_LERPS = 7;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Z   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE = 2'd3;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } t_axis;

    // Lerp schedule over the eight corner registers v[x + 2y + 4z]: four lerps
    // along z, two along y, one along x. Each result replaces its first operand.
    localparam logic [2:0] LRP_SRC_A [8] = '{3'd0, 3'd2, 3'd1, 3'd3, 3'd0, 3'd1, 3'd0, 3'd0};
    localparam logic [2:0] LRP_SRC_B [8] = '{3'd4, 3'd6, 3'd5, 3'd7, 3'd2, 3'd3, 3'd1, 3'd1};
    localparam t_axis      LRP_AXIS  [8] = '{AX_Z, AX_Z, AX_Z, AX_Z, AX_Y, AX_Y, AX_X, AX_X};
    localparam logic [2:0] LRP_LAST      = 3'(NUM_LERPS - 1);

endpackage

/* hdl/vti_if.sv */
// Channel interfaces of the voxel trilinear interpolator: input items,
// result items and configuration writes. Depends on vti_pkg.
interface vti_in_if #(parameter int VALUE_BITS = 32) ();
    logic                                 valid;
    logic                                 ready;
    logic                                 cmd;
    logic [vti_pkg::INDEX_W-1:0]          voxel_index;
    logic signed [VALUE_BITS-1:0]         voxel_value;
    logic [vti_pkg::COORD_W-1:0]          coord_x;
    logic [vti_pkg::COORD_W-1:0]          coord_y;
    logic [vti_pkg::COORD_W-1:0]          coord_z;
    modport source(output valid, cmd, voxel_index, voxel_value, coord_x, coord_y, coord_z,
                   input ready);
    modport sink(input valid, cmd, voxel_index, voxel_value, coord_x, coord_y, coord_z,
                 output ready);
endinterface

interface vti_out_if #(parameter int VALUE_BITS = 32) ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] interp_value;
    logic                         outside;
    modport source(output valid, interp_value, outside, input ready);
    modport sink(input valid, interp_value, outside, output ready);
endinterface

interface vti_cfg_if #(parameter int VALUE_BITS = 32) ();
    logic                            valid;
    logic                            ready;
    logic [vti_pkg::CFG_IDX_W-1:0]   index;
    logic [VALUE_BITS-1:0]           data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* hdl/vti_front.sv */
// Front end: accepts items, classifies them and forms the store address.
// Depends on vti_pkg and vti_if.
module vti_front #(
    parameter int FRAC_BITS  = 16,
    parameter int VALUE_BITS = 32,
    parameter int ADDR_W     = 15,
    parameter int DEPTH      = 32768
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    vti_in_if.sink                       i_in,
    input  logic [vti_pkg::DIM_W-1:0]    i_dim_x,
    input  logic [vti_pkg::DIM_W-1:0]    i_dim_y,
    input  logic [vti_pkg::DIM_W-1:0]    i_dim_z,
    input  logic [vti_pkg::SXY_W-1:0]    i_sxy,
    input  logic                         i_full,
    output logic                         o_push,
    output logic [2+ADDR_W+VALUE_BITS+3*FRAC_BITS:0] o_entry
);

    localparam int CW  = (vti_pkg::DIM_W + FRAC_BITS > vti_pkg::COORD_W) ?
                         vti_pkg::DIM_W + FRAC_BITS : vti_pkg::COORD_W;
    localparam int P1W = vti_pkg::SXY_W;
    localparam int P2W = vti_pkg::SXY_W + vti_pkg::DIM_W;
    localparam int SW  = P2W + 1;

    typedef struct packed {
        logic                         kind;
        logic                         wok;
        logic                         outside;
        logic [ADDR_W-1:0]            addr;
        logic [VALUE_BITS-1:0]        val;
        logic [FRAC_BITS-1:0]         fx;
        logic [FRAC_BITS-1:0]         fy;
        logic [FRAC_BITS-1:0]         fz;
    } t_entry;

    typedef enum logic {S_IDLE, S_PUSH} t_state;

    t_state                       r_state;
    logic                         r_kind, r_wok, r_out;
    logic [vti_pkg::DIM_W-1:0]    r_ix;
    logic [P1W-1:0]               r_p1;
    logic [P2W-1:0]               r_p2;
    logic [vti_pkg::INDEX_W-1:0]  r_widx;
    logic [VALUE_BITS-1:0]        r_val;
    logic [FRAC_BITS-1:0]         r_fx, r_fy, r_fz;
    logic                         accept;
    logic [SW-1:0]                base;
    t_entry                       entry;

    function automatic logic axis_out(input logic [vti_pkg::COORD_W-1:0] c,
                                      input logic [vti_pkg::DIM_W-1:0] d);
        logic [CW-1:0] lim;
        lim = CW'(d - 6'd1) << FRAC_BITS;
        return (c == '0) || (d < 6'd2) || (CW'(c) >= lim);
    endfunction

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_full) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The two index products are taken straight off the accepted word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_in.cmd;
            r_wok   <= (32'(i_in.voxel_index) < 32'(DEPTH));
            r_out   <= axis_out(i_in.coord_x, i_dim_x) || axis_out(i_in.coord_y, i_dim_y) ||
                       axis_out(i_in.coord_z, i_dim_z);
            r_ix    <= vti_pkg::DIM_W'(i_in.coord_x >> FRAC_BITS);
            r_p1    <= P1W'(vti_pkg::DIM_W'(i_in.coord_y >> FRAC_BITS)) * P1W'(i_dim_x);
            r_p2    <= P2W'(vti_pkg::DIM_W'(i_in.coord_z >> FRAC_BITS)) * P2W'(i_sxy);
            r_widx  <= i_in.voxel_index;
            r_val   <= i_in.voxel_value;
            r_fx    <= i_in.coord_x[FRAC_BITS-1:0];
            r_fy    <= i_in.coord_y[FRAC_BITS-1:0];
            r_fz    <= i_in.coord_z[FRAC_BITS-1:0];
        end
    end

    assign base = SW'(r_ix) + SW'(r_p1) + SW'(r_p2);

    always_comb begin
        entry.kind    = r_kind;
        entry.wok     = r_wok;
        entry.outside = r_out;
        entry.addr    = (r_kind == vti_pkg::CMD_WRITE) ? ADDR_W'(r_widx) : ADDR_W'(base);
        entry.val     = r_val;
        entry.fx      = r_fx;
        entry.fy      = r_fy;
        entry.fz      = r_fz;
    end

    assign o_push  = (r_state == S_PUSH) && !i_full;
    assign o_entry = entry;

    a_push_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> $past(r_state) == S_PUSH || $past(accept))
        else $error("front pushed without an accepted item");
    a_no_accept_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH && i_full) |=> r_state == S_PUSH)
        else $error("front dropped an item while the queue was full");
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("front pushed into a full queue");

endmodule

/* hdl/vti_fifo.sv */
// Short queue between the front end and the back end of the interpolator.
// Depends on nothing else.
module vti_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [PW:0]      r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(DEPTH))
        else $error("queue count out of range");

endmodule

/* hdl/vti_back.sv */
// Back end: voxel memory, eight-corner fetch sequencer, shared lerp
// multiplier and the result register. Depends on vti_pkg and vti_if.
module vti_back #(
    parameter int FRAC_BITS  = 16,
    parameter int VALUE_BITS = 32,
    parameter int ADDR_W     = 15,
    parameter int DEPTH      = 32768
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [2+ADDR_W+VALUE_BITS+3*FRAC_BITS:0] i_entry,
    input  logic                              i_empty,
    output logic                              o_pop,
    input  logic [vti_pkg::DIM_W-1:0]         i_sx,
    input  logic [vti_pkg::SXY_W-1:0]         i_sxy,
    input  logic signed [VALUE_BITS-1:0]      i_outside_value,
    vti_out_if.source                         o_res
);

    localparam int W  = VALUE_BITS + 2;
    localparam int PW = W + FRAC_BITS + 2;

    typedef struct packed {
        logic                         kind;
        logic                         wok;
        logic                         outside;
        logic [ADDR_W-1:0]            addr;
        logic [VALUE_BITS-1:0]        val;
        logic [FRAC_BITS-1:0]         fx;
        logic [FRAC_BITS-1:0]         fy;
        logic [FRAC_BITS-1:0]         fz;
    } t_entry;

    typedef enum logic [2:0] {S_IDLE, S_FETCH, S_MUL0, S_MUL1, S_ACC, S_DONE} t_state;

    t_entry                  head;
    t_state                  r_state;
    logic [3:0]              r_cnt;
    logic [2:0]              r_lrp;
    logic [ADDR_W-1:0]       r_base;
    logic [FRAC_BITS-1:0]    r_fx, r_fy, r_fz;
    logic signed [W-1:0]     r_v [8];
    logic signed [W-1:0]     r_prod, r_acc;
    logic [VALUE_BITS-1:0]   r_mem [DEPTH];
    logic [VALUE_BITS-1:0]   r_rdata;
    logic                    r_out_vld, r_out_flag;
    logic [VALUE_BITS-1:0]   r_out_val;
    logic [ADDR_W-1:0]       addr, offs;
    logic                    we, slot_free, load_out;
    logic [FRAC_BITS-1:0]    frac;
    logic [FRAC_BITS:0]      w_a, w_b;
    logic signed [W-1:0]     opnd, sum;
    logic [FRAC_BITS:0]      wsel;

    assign head      = i_entry;
    assign slot_free = !r_out_vld || o_res.ready;

    // Writes and outside answers finish at the pop; an inside query goes on to the fetch.
    assign o_pop = (r_state == S_IDLE) && !i_empty &&
                   (head.kind == vti_pkg::CMD_WRITE || !head.outside || slot_free);
    assign we    = o_pop && head.kind == vti_pkg::CMD_WRITE && head.wok;

    // Corner k sits at base + x + y*sx + z*sx*dy with {z,y,x} the bits of k.
    always_comb begin
        offs = ADDR_W'(r_cnt[0]);
        if (r_cnt[1]) offs = offs + ADDR_W'(i_sx);
        if (r_cnt[2]) offs = offs + ADDR_W'(i_sxy);
        addr = (r_state == S_IDLE) ? head.addr : r_base + offs;
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[addr] <= head.val;
        r_rdata <= r_mem[addr];
    end

    always_comb begin
        case (vti_pkg::LRP_AXIS[r_lrp])
            vti_pkg::AX_X: frac = r_fx;
            vti_pkg::AX_Y: frac = r_fy;
            vti_pkg::AX_Z: frac = r_fz;
            default:       frac = r_fx;
        endcase
        w_b  = (FRAC_BITS+1)'(frac);
        w_a  = (FRAC_BITS+1)'(1) << FRAC_BITS;
        w_a  = w_a - w_b;
        opnd = (r_state == S_MUL0) ? r_v[vti_pkg::LRP_SRC_A[r_lrp]] :
                                     r_v[vti_pkg::LRP_SRC_B[r_lrp]];
        wsel = (r_state == S_MUL0) ? w_a : w_b;
        sum  = r_acc + r_prod;
    end

    function automatic logic signed [W-1:0] scale(input logic signed [W-1:0] v,
                                                  input logic [FRAC_BITS:0] w);
        logic signed [PW-1:0] p;
        p = PW'(v) * $signed({1'b0, w});
        return W'(p >>> FRAC_BITS);
    endfunction

    function automatic logic [VALUE_BITS-1:0] sat(input logic signed [W-1:0] v);
        logic [VALUE_BITS-1:0] mx;
        mx = {1'b0, {(VALUE_BITS-1){1'b1}}};
        if (v[W-1:VALUE_BITS-1] == '0 || v[W-1:VALUE_BITS-1] == '1) return v[VALUE_BITS-1:0];
        return v[W-1] ? ~mx : mx;
    endfunction

    assign load_out = (o_pop && head.kind == vti_pkg::CMD_QUERY && head.outside) ||
                      (r_state == S_DONE && slot_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_lrp     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (load_out)          r_out_vld <= 1'b1;
            else if (o_res.ready)  r_out_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_pop && head.kind == vti_pkg::CMD_QUERY && !head.outside) begin
                        r_state <= S_FETCH;
                        r_cnt   <= '0;
                    end
                end
                S_FETCH: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd8) begin
                        r_state <= S_MUL0;
                        r_lrp   <= '0;
                    end
                end
                S_MUL0: r_state <= S_MUL1;
                S_MUL1: r_state <= S_ACC;
                S_ACC: begin
                    if (r_lrp == vti_pkg::LRP_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_lrp   <= r_lrp + 3'd1;
                        r_state <= S_MUL0;
                    end
                end
                S_DONE: begin
                    if (slot_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_base <= head.addr;
            r_fx   <= head.fx;
            r_fy   <= head.fy;
            r_fz   <= head.fz;
        end
        if (r_state == S_FETCH && r_cnt != 4'd0) begin
            r_v[3'(r_cnt - 4'd1)] <= W'($signed(r_rdata));
        end
        if (r_state == S_MUL0) r_prod <= scale(opnd, wsel);
        if (r_state == S_MUL1) begin
            r_acc  <= r_prod;
            r_prod <= scale(opnd, wsel);
        end
        if (r_state == S_ACC) r_v[vti_pkg::LRP_SRC_A[r_lrp]] <= sum;
        if (load_out) begin
            r_out_flag <= (r_state == S_IDLE);
            r_out_val  <= (r_state == S_IDLE) ? i_outside_value : sat(r_v[0]);
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.interp_value = r_out_val;
    assign o_res.outside      = r_out_flag;

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == S_IDLE)
        else $error("queue popped while a query was in flight");
    a_fetch_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |-> r_cnt <= 4'd8)
        else $error("fetch counter ran past eight corners");
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> slot_free)
        else $error("result register overwritten before it was taken");
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_DONE) |-> $past(r_lrp) == vti_pkg::LRP_LAST)
        else $error("result finished before the last lerp");

endmodule

/* hdl/voxel_trilinear_interpolator_unit.sv */
// Voxel trilinear interpolator, top level: configuration registers, front end,
// queue and back end. A query inside the volume makes eight reads of the
// single-port voxel memory, then seven lerps on one shared multiplier, each
// through S_MUL0, S_MUL1 and S_ACC. The front end takes a new item once the
// last is queued, even with the back end busy. Reset clears control state and
// loads the dimension registers with 32 and the outside value with zero.
module voxel_trilinear_interpolator_unit #(
    parameter int MAX_DIM    = 32,
    parameter int FRAC_BITS  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vti_in_if.sink      i_in,
    vti_cfg_if.sink     i_cfg,
    vti_out_if.source   o_res
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DCAP   = (MAX_DIM < 63) ? MAX_DIM : 63;
    localparam int EW     = 3 + ADDR_W + VALUE_BITS + 3 * FRAC_BITS;

    logic [vti_pkg::DIM_W-1:0]   r_dim_x, r_dim_y, r_dim_z;
    logic [vti_pkg::DIM_W-1:0]   dx, dy, dz;
    logic [vti_pkg::SXY_W-1:0]   r_sxy;
    logic signed [VALUE_BITS-1:0] r_outside;
    logic                        push, pop, full, empty;
    logic [EW-1:0]               entry_in, entry_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x   <= 6'd32;
            r_dim_y   <= 6'd32;
            r_dim_z   <= 6'd32;
            r_outside <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                vti_pkg::REG_DIM_X:   r_dim_x   <= i_cfg.data[vti_pkg::DIM_W-1:0];
                vti_pkg::REG_DIM_Y:   r_dim_y   <= i_cfg.data[vti_pkg::DIM_W-1:0];
                vti_pkg::REG_DIM_Z:   r_dim_z   <= i_cfg.data[vti_pkg::DIM_W-1:0];
                vti_pkg::REG_OUTSIDE: r_outside <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Dimensions above the store size behave as the store size.
    assign dx = (r_dim_x > 6'(DCAP)) ? 6'(DCAP) : r_dim_x;
    assign dy = (r_dim_y > 6'(DCAP)) ? 6'(DCAP) : r_dim_y;
    assign dz = (r_dim_z > 6'(DCAP)) ? 6'(DCAP) : r_dim_z;

    always_ff @(posedge i_clk) begin
        r_sxy <= vti_pkg::SXY_W'(dx) * vti_pkg::SXY_W'(dy);
    end

    vti_front #(
        .FRAC_BITS(FRAC_BITS), .VALUE_BITS(VALUE_BITS), .ADDR_W(ADDR_W), .DEPTH(DEPTH)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .i_dim_x(dx), .i_dim_y(dy), .i_dim_z(dz), .i_sxy(r_sxy),
        .i_full(full), .o_push(push), .o_entry(entry_in)
    );

    vti_fifo #(.WIDTH(EW), .DEPTH(4)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(entry_in),
        .i_pop(pop), .o_data(entry_out), .o_full(full), .o_empty(empty)
    );

    vti_back #(
        .FRAC_BITS(FRAC_BITS), .VALUE_BITS(VALUE_BITS), .ADDR_W(ADDR_W), .DEPTH(DEPTH)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_entry(entry_out), .i_empty(empty),
        .o_pop(pop), .i_sx(dx), .i_sxy(r_sxy), .i_outside_value(r_outside),
        .o_res(o_res)
    );

endmodule

/* verif/tb.sv */
// Self-checking testbench for voxel_trilinear_interpolator_unit.
// Depends on hdl/vti_pkg.sv, hdl/vti_if.sv and the RTL; it predicts every result
// from its own copies of the voxel store and registers; checks results in order.
`timescale 1ns / 1ps

module tb;

    localparam int  INDEX_W     = vti_pkg::INDEX_W;
    localparam int  COORD_W     = vti_pkg::COORD_W;
    localparam int  DIM_W       = vti_pkg::DIM_W;
    localparam int  CFG_IDX_W   = vti_pkg::CFG_IDX_W;
    localparam int  STORE_DEPTH = 32768;
    localparam int  FRAC        = 16;
    localparam longint VMAX     = 64'sd2147483647;
    localparam longint VMIN     = -64'sd2147483648;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct {
        logic                     cmd;
        logic [INDEX_W-1:0]       idx;
        logic signed [31:0]       val;
        logic [COORD_W-1:0]       cx;
        logic [COORD_W-1:0]       cy;
        logic [COORD_W-1:0]       cz;
    } t_voxel_word;

    typedef struct {
        logic signed [31:0] value;
        logic               outside;
    } t_interp_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    vti_in_if  #(32) in_if ();
    vti_cfg_if #(32) cfg_if ();
    vti_out_if #(32) res_if ();

    voxel_trilinear_interpolator_unit #(.MAX_DIM(32), .FRAC_BITS(16), .VALUE_BITS(32)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    // Shadow state of the block.
    logic signed [31:0] voxel_mem [STORE_DEPTH];
    bit                 voxel_written [STORE_DEPTH];
    logic [DIM_W-1:0]   dim_reg [3];
    logic signed [31:0] outside_reg;

    t_interp_result     pending_results [$];
    int                 mismatches = 0;
    longint             cycles = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 sent_words = 0;

    function automatic int eff_dim(logic [DIM_W-1:0] d);
        return (d > 32) ? 32 : int'(d);
    endfunction

    function automatic bit axis_out(logic [COORD_W-1:0] c, int d);
        if (d < 2 || c == 0) return 1'b1;
        return c >= (COORD_W'(d - 1) << FRAC);
    endfunction

    // floor(v * w / 2^16); w never exceeds 2^16, so the product fits easily.
    function automatic longint scale_fx(longint v, longint w);
        longint p;
        p = v * w;
        return p >>> FRAC;
    endfunction

    function automatic longint lerp_fx(longint a, longint b, longint f);
        return scale_fx(a, 65536 - f) + scale_fx(b, f);
    endfunction

    function automatic int cell_base(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                     logic [COORD_W-1:0] cz);
        int sx, sxy;
        sx  = eff_dim(dim_reg[0]);
        sxy = sx * eff_dim(dim_reg[1]);
        return int'(cx >> FRAC) + int'(cy >> FRAC) * sx + int'(cz >> FRAC) * sxy;
    endfunction

    function automatic int corner_index(int base, int k);
        int sx, sxy;
        sx  = eff_dim(dim_reg[0]);
        sxy = sx * eff_dim(dim_reg[1]);
        return base + (k & 1) + ((k >> 1) & 1) * sx + ((k >> 2) & 1) * sxy;
    endfunction

    function automatic bit query_is_outside(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                            logic [COORD_W-1:0] cz);
        return axis_out(cx, eff_dim(dim_reg[0])) || axis_out(cy, eff_dim(dim_reg[1]))
            || axis_out(cz, eff_dim(dim_reg[2]));
    endfunction

    function automatic t_interp_result predict_interp(logic [COORD_W-1:0] cx,
                                                      logic [COORD_W-1:0] cy,
                                                      logic [COORD_W-1:0] cz);
        t_interp_result r;
        longint c [8];
        longint fx, fy, fz, e, g, y;
        int base;
        if (query_is_outside(cx, cy, cz)) begin
            r.value = outside_reg;
            r.outside = 1'b1;
            return r;
        end
        fx = longint'(cx[FRAC-1:0]);
        fy = longint'(cy[FRAC-1:0]);
        fz = longint'(cz[FRAC-1:0]);
        base = cell_base(cx, cy, cz);
        for (int k = 0; k < 8; k++) c[k] = longint'(voxel_mem[corner_index(base, k)]);
        e = lerp_fx(lerp_fx(c[0], c[4], fz), lerp_fx(c[2], c[6], fz), fy);
        g = lerp_fx(lerp_fx(c[1], c[5], fz), lerp_fx(c[3], c[7], fz), fy);
        y = lerp_fx(e, g, fx);
        if (y > VMAX) y = VMAX;
        if (y < VMIN) y = VMIN;
        r.value = 32'(y);
        r.outside = 1'b0;
        return r;
    endfunction

    // Sends one word, waiting out the random sender gaps, and updates the shadow state.
    task automatic send_word(t_voxel_word w);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       = 1'b1;
        in_if.cmd         = w.cmd;
        in_if.voxel_index = w.idx;
        in_if.voxel_value = w.val;
        in_if.coord_x     = w.cx;
        in_if.coord_y     = w.cy;
        in_if.coord_z     = w.cz;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sent_words++;
        if (w.cmd == vti_pkg::CMD_WRITE) begin
            voxel_mem[w.idx] = w.val;
            voxel_written[w.idx] = 1'b1;
        end else begin
            pending_results.push_back(predict_interp(w.cx, w.cy, w.cz));
        end
    endtask

    task automatic write_voxel(int idx, logic signed [31:0] val);
        t_voxel_word w;
        w = '{cmd: vti_pkg::CMD_WRITE, idx: INDEX_W'(idx), val: val,
              cx: COORD_W'($urandom), cy: COORD_W'($urandom), cz: COORD_W'($urandom)};
        send_word(w);
    endtask

    task automatic query_point(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                               logic [COORD_W-1:0] cz);
        t_voxel_word w;
        w = '{cmd: vti_pkg::CMD_QUERY, idx: INDEX_W'($urandom), val: $urandom,
              cx: cx, cy: cy, cz: cz};
        send_word(w);
    endtask

    // For an inside point, writes random values into any corner of the cell not yet written, then queries.
    task automatic query_inside(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                logic [COORD_W-1:0] cz);
        int base, idx;
        if (!query_is_outside(cx, cy, cz)) begin
            base = cell_base(cx, cy, cz);
            for (int k = 0; k < 8; k++) begin
                idx = corner_index(base, k);
                if (!voxel_written[idx]) write_voxel(idx, $urandom);
            end
        end
        query_point(cx, cy, cz);
    endtask

    task automatic fill_cell(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                             logic [COORD_W-1:0] cz, logic signed [31:0] lo,
                             logic signed [31:0] hi);
        int base;
        base = cell_base(cx, cy, cz);
        for (int k = 0; k < 8; k++) write_voxel(corner_index(base, k), k[0] ? hi : lo);
    endtask

    function automatic logic [COORD_W-1:0] rand_inside_coord(int d);
        logic [COORD_W-1:0] c;
        c = (COORD_W'($urandom_range(d - 2)) << FRAC) | COORD_W'($urandom_range(65535));
        if (c == 0) c = 1;
        return c;
    endfunction

    // Idle point: no word offered, every result in, then the block's own latency.
    task automatic drain_all();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            vti_pkg::REG_DIM_X:   dim_reg[0] = data[DIM_W-1:0];
            vti_pkg::REG_DIM_Y:   dim_reg[1] = data[DIM_W-1:0];
            vti_pkg::REG_DIM_Z:   dim_reg[2] = data[DIM_W-1:0];
            vti_pkg::REG_OUTSIDE: outside_reg = data;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic set_volume(int dx, int dy, int dz, logic [31:0] outside_val);
        drain_all();
        write_reg(vti_pkg::REG_DIM_X, 32'(dx));
        write_reg(vti_pkg::REG_DIM_Y, 32'(dy));
        write_reg(vti_pkg::REG_DIM_Z, 32'(dz));
        write_reg(vti_pkg::REG_OUTSIDE, outside_val);
    endtask

    task automatic test_directed();
        logic [COORD_W-1:0] top;
        top = (COORD_W'(31) << FRAC) - 1;
        fill_cell(1, 1, 1, 32'sh8000_0000, 32'sh7FFF_FFFF);
        query_point(1, 1, 1);
        query_point(COORD_W'(65535), COORD_W'(65535), COORD_W'(65535));
        query_point(COORD_W'(32768), 1, 1);
        fill_cell(top, top, top, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        query_point(top, top, top);
        fill_cell(top, top, top, 32'sh8000_0000, 32'sh8000_0000);
        query_point(top, top, top);
        query_point(0, 1, 1);
        query_point(1, 1, 0);
        query_point(COORD_W'(31) << FRAC, 1, 1);
        query_point(1, 1, {COORD_W{1'b1}});
        query_point({COORD_W{1'b1}}, {COORD_W{1'b1}}, {COORD_W{1'b1}});
    endtask

    task automatic test_dims_extremes();
        // The smallest volume has a single interior cell.
        set_volume(2, 2, 2, 32'h8000_0000);
        fill_cell(1, 1, 1, 32'sh0001_0000, -32'sh0003_0000);
        query_point(1, 1, 1);
        query_point(COORD_W'(65535), COORD_W'(40000), COORD_W'(1234));
        query_point(COORD_W'(1) << FRAC, 1, 1);
        // Dimensions below two leave no interior at all.
        set_volume(1, 0, 32, 32'h7FFF_FFFF);
        query_point(COORD_W'(1), COORD_W'(1), COORD_W'(1));
        query_point(COORD_W'(40000), COORD_W'(90000), COORD_W'(5000));
        // Dimensions above the maximum act as the maximum.
        set_volume(63, 33, 40, 32'h1234_5678);
        query_inside(rand_inside_coord(32), rand_inside_coord(32), rand_inside_coord(32));
        query_inside((COORD_W'(31) << FRAC) - 1, COORD_W'(77), COORD_W'(3) << FRAC);
        query_point(COORD_W'(31) << FRAC, COORD_W'(77), COORD_W'(77));
    endtask

    // Sends about n_words words, counting the corner writes that queries bring along.
    task automatic test_random(int n_words, int s_idle, int r_idle);
        int dice, start;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        start = sent_words;
        while (sent_words - start < n_words) begin
            dice = $urandom_range(99);
            if (dice < 60) begin
                query_inside(rand_inside_coord(eff_dim(dim_reg[0])),
                             rand_inside_coord(eff_dim(dim_reg[1])),
                             rand_inside_coord(eff_dim(dim_reg[2])));
            end else if (dice < 80) begin
                write_voxel($urandom_range(STORE_DEPTH - 1), $urandom);
            end else if (dice < 90) begin
                query_inside(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
            end else begin
                // Points on the faces of the interior, which must answer outside.
                query_point(COORD_W'(eff_dim(dim_reg[0]) - 1) << FRAC,
                            rand_inside_coord(eff_dim(dim_reg[1])),
                            (dice & 1) ? COORD_W'(0) : rand_inside_coord(eff_dim(dim_reg[2])));
            end
        end
    endtask

    always @(negedge i_clk) begin
        res_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_interp_result exp_r;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: value=%h outside=%b",
                             res_if.interp_value, res_if.outside);
            end else begin
                exp_r = pending_results.pop_front();
                if (res_if.interp_value !== exp_r.value || res_if.outside !== exp_r.outside) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: expected value=%h outside=%b,",
                                 $realtime, exp_r.value, exp_r.outside,
                                 " got value=%h outside=%b",
                                 res_if.interp_value, res_if.outside);
                end
            end
        end
    end

    initial begin
        in_if.valid = 1'b0;
        in_if.cmd = vti_pkg::CMD_WRITE;
        in_if.voxel_index = '0;
        in_if.voxel_value = '0;
        in_if.coord_x = '0;
        in_if.coord_y = '0;
        in_if.coord_z = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = vti_pkg::REG_DIM_X;
        cfg_if.data = '0;
        res_if.ready = 1'b0;
        for (int i = 0; i < 3; i++) dim_reg[i] = 6'd32;
        outside_reg = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 10;
        recv_idle_pct = 73;
        test_directed();
        test_dims_extremes();
        set_volume(5, 4, 3, 32'hDEAD_BEEF);
        test_random(130, 10, 73);
        set_volume(32, 32, 32, 32'h8000_0000);
        test_random(130, 73, 10);
        set_volume(3, 31, 17, 32'h7FFF_FFFF);
        test_random(130, 0, 0);
        drain_all();

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/vti_pkg.sv
hdl/vti_if.sv
hdl/vti_front.sv
hdl/vti_fifo.sv
hdl/vti_back.sv
hdl/voxel_trilinear_interpolator_unit.sv
verif/tb.sv
